// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define PRS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define PRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/prs_pkg.sv =====
// Shared types and constants of the priority ready-set scheduler.
package prs_pkg;

    localparam int MODE_W  = 2;
    localparam int PRIO_W  = 6;
    localparam int TICKS_W = 32;
    localparam int ERR_W   = 2;

    // Width of one slice of the ready mask examined per cycle by the search.
    localparam int SCAN_W  = 8;

    localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELAY    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REGISTER = 2'd2;

    localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
    localparam logic [ERR_W-1:0] ERR_IDLE      = 2'd1;
    localparam logic [ERR_W-1:0] ERR_ZERO      = 2'd2;
    localparam logic [ERR_W-1:0] ERR_PRIO_USED = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_SCAN,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/prs_in_if.sv =====
// Command channel carrying one scheduler transaction per handshake.
interface prs_in_if;
    logic                        valid;
    logic                        ready;
    logic [prs_pkg::MODE_W-1:0]  mode;
    logic [prs_pkg::PRIO_W-1:0]  thread_priority;
    logic [prs_pkg::TICKS_W-1:0] delay_ticks;

    modport source (output valid, output mode, output thread_priority,
                    output delay_ticks, input ready);
    modport sink   (input valid, input mode, input thread_priority,
                    input delay_ticks, output ready);
endinterface

// ===== rtl/prs_out_if.sv =====
// Result channel carrying the scheduling decision of each transaction.
interface prs_out_if;
    logic                       valid;
    logic                       ready;
    logic [prs_pkg::PRIO_W-1:0] next_thread;
    logic                       switch_request;
    logic [prs_pkg::ERR_W-1:0]  error_code;

    modport source (output valid, output next_thread, output switch_request,
                    output error_code, input ready);
    modport sink   (input valid, input next_thread, input switch_request,
                    input error_code, output ready);
endinterface

// ===== rtl/prs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module prs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/prs_tmo_unit.sv =====
// Timeout arithmetic unit: arms a counter or decrements it and flags expiry.
module prs_tmo_unit #(
    parameter int TIMEOUT_BITS = 32
) (
    input  logic                    arm,
    input  logic [TIMEOUT_BITS-1:0] ticks,
    input  logic [TIMEOUT_BITS-1:0] count,
    output logic [TIMEOUT_BITS-1:0] wdata,
    output logic                    expired,
    output logic                    ticks_zero
);

    // A counter of one or zero runs out on this tick.
    assign expired    = (count[TIMEOUT_BITS-1:1] == '0);
    assign ticks_zero = (ticks == '0);

    always_comb
    begin
        if (arm)
        begin
            wdata = ticks;
        end
        else if (expired)
        begin
            wdata = '0;
        end
        else
        begin
            wdata = count - TIMEOUT_BITS'(1);
        end
    end

endmodule

// ===== rtl/prs_scan.sv =====
// Multi-cycle search for the highest set bit of the ready mask, one slice a cycle.
module prs_scan #(
    parameter int NUM_PRIORITIES = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [NUM_PRIORITIES-1:0]         mask,
    output logic                              done,
    output logic [$clog2(NUM_PRIORITIES+1)-1:0] prio
);

    localparam int SW   = prs_pkg::SCAN_W;
    localparam int SWB  = $clog2(SW);
    localparam int NCH  = (NUM_PRIORITIES + SW - 1) / SW;
    localparam int CW   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PADW = (2 ** CW) * SW;
    localparam int PW   = $clog2(NUM_PRIORITIES + 1);

    logic          busy_reg;
    logic [CW-1:0] chunk_reg;
    logic [PADW-1:0] pad;
    logic [SW-1:0]   slice;
    logic [SWB-1:0]  msb;

    assign pad   = PADW'(mask);
    assign slice = pad[chunk_reg * SW +: SW];

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < SW; i++)
        begin
            if (slice[i])
            begin
                msb = SWB'(i);
            end
        end
    end

    // The search ends at the first non-empty slice from the top, or at the bottom slice.
    assign done = busy_reg && ((slice != '0) || (chunk_reg == '0));
    assign prio = (slice != '0) ? PW'({1'b0, chunk_reg, msb} + (CW + SWB + 1)'(1)) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            chunk_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            chunk_reg <= CW'(NCH - 1);
        end
        else if (busy_reg)
        begin
            if (done)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                chunk_reg <= chunk_reg - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/priority_ready_set_scheduler.sv =====
// Top level of the priority ready-set thread scheduler.
//
// The block takes commands on the cmd channel and returns one result per
// transaction on the res channel; both use a valid/ready handshake. A command
// is a tick, a delay of the running thread, or the registration of a thread.
// Each result gives the chosen thread, a switch flag and an error code.
// One transaction is worked on at a time and cmd.ready is high only while the
// sequencer is idle. A tick walks the timeout memory, one entry a cycle
// through the shared decrement unit, and then runs the ready-mask search;
// the search looks at eight priorities a cycle from the top. A delay, a
// registration or an unused mode goes straight to the search. The result
// sits in an output register, so a stalled receiver does not stop the next
// command from being accepted; only when a second result is ready before the
// first is taken does the sequencer wait. Reset clears every mask, the
// running thread and the channels; the timeout memory needs no clearing,
// since an entry is used only after its thread has been delayed.
`include "assert_macros.svh"

module priority_ready_set_scheduler #(
    parameter int NUM_PRIORITIES = 32,
    parameter int TIMEOUT_BITS   = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    prs_in_if.sink     cmd,
    prs_out_if.source  res
);

    localparam int MW = $clog2(NUM_PRIORITIES);
    localparam int PW = $clog2(NUM_PRIORITIES + 1);

    prs_pkg::state_t state_reg, state_next;

    logic [NUM_PRIORITIES-1:0] ready_mask_reg, ready_mask_next;
    logic [NUM_PRIORITIES-1:0] delayed_mask_reg, delayed_mask_next;
    logic [NUM_PRIORITIES:0]   registered_mask_reg, registered_mask_next;
    logic [PW-1:0]             cur_reg, cur_next;
    logic                      cur_valid_reg, cur_valid_next;
    logic [MW:0]               rd_idx_reg, rd_idx_next;
    logic                      pend_valid_reg, pend_valid_next;
    logic [MW-1:0]             pend_idx_reg, pend_idx_next;
    logic [prs_pkg::ERR_W-1:0] err_reg, err_next;
    logic [PW-1:0]             res_prio_reg, res_prio_next;

    logic                       out_valid_reg, out_valid_next;
    logic [prs_pkg::PRIO_W-1:0] out_thread_reg, out_thread_next;
    logic                       out_switch_reg, out_switch_next;
    logic [prs_pkg::ERR_W-1:0]  out_err_reg, out_err_next;

    logic                    accept;
    logic [PW:0]             prio_ext;
    logic                    prio_oor;
    logic [PW-1:0]           prio_idx;
    logic [MW-1:0]           prio_bit;
    logic [MW-1:0]           cur_bit;
    logic                    cur_idle;

    logic                    ram_we;
    logic [MW-1:0]           ram_waddr;
    logic                    ram_re;
    logic [TIMEOUT_BITS-1:0] ram_rdata;

    logic                    tmo_arm;
    logic [TIMEOUT_BITS-1:0] tmo_ticks;
    logic [TIMEOUT_BITS-1:0] tmo_wdata;
    logic                    tmo_expired;
    logic                    tmo_ticks_zero;

    logic                    scan_start;
    logic                    scan_done;
    logic [PW-1:0]           scan_prio;

    // Helpers for the checks at the end of the module.
    logic [NUM_PRIORITIES-1:0]                    unreg_active;
    logic                                         out_stalled;
    logic [prs_pkg::PRIO_W+prs_pkg::ERR_W:0]      held_result;

    assign cmd.ready          = (state_reg == prs_pkg::ST_IDLE);
    assign accept             = cmd.valid && cmd.ready;
    assign res.valid          = out_valid_reg;
    assign res.next_thread    = out_thread_reg;
    assign res.switch_request = out_switch_reg;
    assign res.error_code     = out_err_reg;

    // The requested priority is widened by a bit so that the range check sees
    // every value of the field when there are at least 16 priorities.
    assign prio_ext = (PW + 1)'(cmd.thread_priority);
    assign prio_oor = (prio_ext > (PW + 1)'(NUM_PRIORITIES));
    assign prio_idx = prio_ext[PW-1:0];
    assign prio_bit = MW'(prio_idx - PW'(1));
    assign cur_bit  = MW'(cur_reg - PW'(1));
    assign cur_idle = !cur_valid_reg || (cur_reg == '0);

    // The timeout unit arms a counter when a command arrives and otherwise
    // decrements the entry that the tick walk has just read.
    assign tmo_arm   = (state_reg == prs_pkg::ST_IDLE);
    assign tmo_ticks = TIMEOUT_BITS'(cmd.delay_ticks);

    prs_tmo_unit #(
        .TIMEOUT_BITS (TIMEOUT_BITS)
    ) u_tmo (
        .arm        (tmo_arm),
        .ticks      (tmo_ticks),
        .count      (ram_rdata),
        .wdata      (tmo_wdata),
        .expired    (tmo_expired),
        .ticks_zero (tmo_ticks_zero)
    );

    prs_ram #(
        .WIDTH (TIMEOUT_BITS),
        .DEPTH (NUM_PRIORITIES)
    ) u_timeout_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (tmo_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg[MW-1:0]),
        .rdata (ram_rdata)
    );

    prs_scan #(
        .NUM_PRIORITIES (NUM_PRIORITIES)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_start),
        .mask  (ready_mask_reg),
        .done  (scan_done),
        .prio  (scan_prio)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= prs_pkg::ST_IDLE;
            ready_mask_reg      <= '0;
            delayed_mask_reg    <= '0;
            registered_mask_reg <= '0;
            cur_reg             <= '0;
            cur_valid_reg       <= 1'b0;
            rd_idx_reg          <= '0;
            pend_valid_reg      <= 1'b0;
            pend_idx_reg        <= '0;
            err_reg             <= prs_pkg::ERR_OK;
            res_prio_reg        <= '0;
            out_valid_reg       <= 1'b0;
            out_thread_reg      <= '0;
            out_switch_reg      <= 1'b0;
            out_err_reg         <= prs_pkg::ERR_OK;
        end
        else
        begin
            state_reg           <= state_next;
            ready_mask_reg      <= ready_mask_next;
            delayed_mask_reg    <= delayed_mask_next;
            registered_mask_reg <= registered_mask_next;
            cur_reg             <= cur_next;
            cur_valid_reg       <= cur_valid_next;
            rd_idx_reg          <= rd_idx_next;
            pend_valid_reg      <= pend_valid_next;
            pend_idx_reg        <= pend_idx_next;
            err_reg             <= err_next;
            res_prio_reg        <= res_prio_next;
            out_valid_reg       <= out_valid_next;
            out_thread_reg      <= out_thread_next;
            out_switch_reg      <= out_switch_next;
            out_err_reg         <= out_err_next;
        end
    end

    always_comb
    begin
        state_next           = state_reg;
        ready_mask_next      = ready_mask_reg;
        delayed_mask_next    = delayed_mask_reg;
        registered_mask_next = registered_mask_reg;
        cur_next             = cur_reg;
        cur_valid_next       = cur_valid_reg;
        rd_idx_next          = rd_idx_reg;
        pend_valid_next      = pend_valid_reg;
        pend_idx_next        = pend_idx_reg;
        err_next             = err_reg;
        res_prio_next        = res_prio_reg;
        out_valid_next       = out_valid_reg;
        out_thread_next      = out_thread_reg;
        out_switch_next      = out_switch_reg;
        out_err_next         = out_err_reg;
        ram_we               = 1'b0;
        ram_waddr            = pend_idx_reg;
        ram_re               = 1'b0;
        scan_start           = 1'b0;

        // A result that the receiver takes frees the output register.
        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            prs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    err_next   = prs_pkg::ERR_OK;
                    scan_start = 1'b1;
                    state_next = prs_pkg::ST_SCAN;
                    case (cmd.mode)
                        prs_pkg::MODE_TICK:
                        begin
                            scan_start      = 1'b0;
                            rd_idx_next     = '0;
                            pend_valid_next = 1'b0;
                            state_next      = prs_pkg::ST_TICK;
                        end
                        prs_pkg::MODE_DELAY:
                        begin
                            // Delaying the idle thread outranks a zero count.
                            if (cur_idle)
                            begin
                                err_next = prs_pkg::ERR_IDLE;
                            end
                            else if (tmo_ticks_zero)
                            begin
                                err_next = prs_pkg::ERR_ZERO;
                            end
                            else
                            begin
                                ram_we                     = 1'b1;
                                ram_waddr                  = cur_bit;
                                ready_mask_next[cur_bit]   = 1'b0;
                                delayed_mask_next[cur_bit] = 1'b1;
                            end
                        end
                        prs_pkg::MODE_REGISTER:
                        begin
                            if (prio_oor || registered_mask_reg[prio_idx])
                            begin
                                err_next = prs_pkg::ERR_PRIO_USED;
                            end
                            else
                            begin
                                registered_mask_next[prio_idx] = 1'b1;
                                // The idle thread is only marked as used.
                                if (prio_idx != '0)
                                begin
                                    ready_mask_next[prio_bit] = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            err_next = prs_pkg::ERR_OK;
                        end
                    endcase
                end
            end

            prs_pkg::ST_TICK:
            begin
                // Write back the entry read in the previous cycle while the
                // next one is read, so the walk handles one entry per cycle.
                if (pend_valid_reg && delayed_mask_reg[pend_idx_reg])
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_idx_reg;
                    if (tmo_expired)
                    begin
                        delayed_mask_next[pend_idx_reg] = 1'b0;
                        ready_mask_next[pend_idx_reg]   = 1'b1;
                    end
                end
                if (rd_idx_reg < (MW + 1)'(NUM_PRIORITIES))
                begin
                    ram_re          = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_idx_next   = rd_idx_reg[MW-1:0];
                    rd_idx_next     = rd_idx_reg + (MW + 1)'(1);
                end
                else
                begin
                    pend_valid_next = 1'b0;
                    if (!pend_valid_reg)
                    begin
                        scan_start = 1'b1;
                        state_next = prs_pkg::ST_SCAN;
                    end
                end
            end

            prs_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    res_prio_next = scan_prio;
                    state_next    = prs_pkg::ST_OUT;
                end
            end

            prs_pkg::ST_OUT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_thread_next = prs_pkg::PRIO_W'(res_prio_reg);
                    out_switch_next = !cur_valid_reg || (res_prio_reg != cur_reg);
                    out_err_next    = err_reg;
                    cur_next        = res_prio_reg;
                    cur_valid_next  = 1'b1;
                    state_next      = prs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = prs_pkg::ST_IDLE;
            end
        endcase
    end

    assign unreg_active = (ready_mask_reg | delayed_mask_reg)
                        & ~registered_mask_reg[NUM_PRIORITIES:1];
    assign out_stalled  = out_valid_reg && !res.ready;
    assign held_result  = {out_valid_reg, out_thread_reg, out_err_reg};

    // A thread is never both ready and waiting on its timeout.
    `PRS_ASSERT_ALWAYS(a_masks_disjoint, (ready_mask_reg & delayed_mask_reg) == '0, "masks overlap")

    // Only registered priorities may be ready or delayed.
    `PRS_ASSERT_ALWAYS(a_only_registered, unreg_active == '0, "unregistered priority scheduled")

    // After a command is taken the block is busy in the next cycle.
    `PRS_ASSERT_NEXT(a_busy_after_accept, accept, !cmd.ready, "ready right after a command")

    // A result waiting on the receiver stays in place until it is taken.
    `PRS_ASSERT_NEXT(a_out_no_overwrite, out_stalled, $stable(held_result), "result overwritten")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the priority ready-set thread scheduler.
//
// The testbench drives commands on the cmd channel and checks results on the
// res channel. It keeps its own model of the scheduler: the ready, delayed and
// claimed sets, the per-priority wait counters and the running thread. Each
// accepted command transaction updates that model and queues the result it
// should produce. A separate process compares every result transaction, field
// by field, with the oldest queued result.
//
// The stimulus runs as a series of named tests. Directed tests cover the
// error paths, the idle thread, out-of-range priorities, zero and maximal
// delays and wake-up on a tick. A long random test then mixes ticks, delays,
// registrations and the unused mode. The sender works in bursts separated by
// gaps, and the receiver applies back-pressure in changing patterns.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRIO_COUNT   = 32;
    localparam int WAIT_BITS    = 32;
    localparam int RANDOM_ITEMS = 750;

    // The quiet spell allowed once the last expected result has arrived.
    localparam int SETTLE_CYCLES = 60;

    // The mode value that the block accepts but does nothing with.
    localparam logic [prs_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [prs_pkg::PRIO_W-1:0] next_thread;
        logic                       switch_request;
        logic [prs_pkg::ERR_W-1:0]  error_code;
    } sched_result_t;

    logic clk;
    logic rst_n;

    prs_in_if  cmd_bus ();
    prs_out_if res_bus ();

    priority_ready_set_scheduler #(
        .NUM_PRIORITIES (PRIO_COUNT),
        .TIMEOUT_BITS   (WAIT_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .res   (res_bus)
    );

    // Scheduler state as the testbench expects it to be.
    logic [PRIO_COUNT-1:0]      ready_set;
    logic [PRIO_COUNT-1:0]      delayed_set;
    logic [PRIO_COUNT:0]        claimed_set;
    logic [WAIT_BITS-1:0]       wait_left [PRIO_COUNT];
    logic [prs_pkg::PRIO_W-1:0] running_thread;
    bit                         running_known;

    // Results owed by the block, oldest first.
    sched_result_t owed_results [$];

    // Sender bookkeeping: the number of transactions left in the current
    // burst, and whether valid has been left high for the next one.
    int burst_left;
    bit cmd_held;

    int mismatch_count;
    int tick_count;
    int delay_count;
    int register_count;
    int unused_count;
    int error_seen [4];
    int switch_seen;

    // The clock: 10 ns period, starting low.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Applies one command to the expected state and returns the result that
    // the block should report for it. Rejected commands leave every set and
    // counter untouched, but the choice of thread is still made.
    function automatic sched_result_t schedule_step(
        input logic [prs_pkg::MODE_W-1:0]  op,
        input logic [prs_pkg::PRIO_W-1:0]  prio,
        input logic [prs_pkg::TICKS_W-1:0] ticks);
        sched_result_t              outcome;
        logic [prs_pkg::ERR_W-1:0]  err;
        logic [prs_pkg::PRIO_W-1:0] pick;
        err = prs_pkg::ERR_OK;
        case (op)
            prs_pkg::MODE_TICK:
            begin
                // Every waiting thread counts down; a counter at one or below
                // expires, and its thread becomes ready again.
                for (int i = 0; i < PRIO_COUNT; i++)
                begin
                    if (delayed_set[i])
                    begin
                        if (wait_left[i] <= 1)
                        begin
                            wait_left[i]   = '0;
                            delayed_set[i] = 1'b0;
                            ready_set[i]   = 1'b1;
                        end
                        else
                        begin
                            wait_left[i] = wait_left[i] - 1'b1;
                        end
                    end
                end
            end
            prs_pkg::MODE_DELAY:
            begin
                // Delaying with nobody running counts as a delay from idle,
                // and that error wins over a zero tick count.
                if (!running_known || running_thread == 0 || running_thread > PRIO_COUNT)
                    err = prs_pkg::ERR_IDLE;
                else if (ticks[WAIT_BITS-1:0] == 0)
                    err = prs_pkg::ERR_ZERO;
                else
                begin
                    wait_left[running_thread - 1]   = ticks[WAIT_BITS-1:0];
                    ready_set[running_thread - 1]   = 1'b0;
                    delayed_set[running_thread - 1] = 1'b1;
                end
            end
            prs_pkg::MODE_REGISTER:
            begin
                // Priorities above the top one are refused as if already used.
                // The idle thread is only marked as claimed.
                if (prio > PRIO_COUNT || claimed_set[prio])
                    err = prs_pkg::ERR_PRIO_USED;
                else
                begin
                    claimed_set[prio] = 1'b1;
                    if (prio != 0)
                        ready_set[prio - 1] = 1'b1;
                end
            end
            default:
            begin
                // The unused mode only runs the choice of thread.
            end
        endcase

        pick = '0;
        for (int i = 0; i < PRIO_COUNT; i++)
        begin
            if (ready_set[i])
                pick = prs_pkg::PRIO_W'(i + 1);
        end

        outcome.next_thread    = pick;
        outcome.switch_request = !running_known || pick != running_thread;
        outcome.error_code     = err;
        running_thread = pick;
        running_known  = 1'b1;
        return outcome;
    endfunction

    // Sends one command transaction. Within a burst valid stays high from one
    // transaction to the next; a new burst begins only after a gap with valid
    // low, so valid is never lowered and raised in the same time step.
    task automatic send_command(input logic [prs_pkg::MODE_W-1:0]  op,
                                input logic [prs_pkg::PRIO_W-1:0]  prio,
                                input logic [prs_pkg::TICKS_W-1:0] ticks);
        int gap;
        if (!cmd_held)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                              : $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        cmd_bus.valid           <= 1'b1;
        cmd_bus.mode            <= op;
        cmd_bus.thread_priority <= prio;
        cmd_bus.delay_ticks     <= ticks;

        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);

        // The transaction has been taken at this edge.
        owed_results.push_back(schedule_step(op, prio, ticks));
        case (op)
            prs_pkg::MODE_TICK:     tick_count++;
            prs_pkg::MODE_DELAY:    delay_count++;
            prs_pkg::MODE_REGISTER: register_count++;
            default:                unused_count++;
        endcase
        burst_left--;

        @(negedge clk);
        if (burst_left == 0)
        begin
            cmd_bus.valid <= 1'b0;
            cmd_held = 1'b0;
        end
        else
        begin
            cmd_held = 1'b1;
        end
    endtask

    // Ends the current burst and waits until every owed result has been
    // received; returns at a falling edge.
    task automatic wait_until_drained();
        if (cmd_held)
        begin
            cmd_bus.valid <= 1'b0;
            cmd_held = 1'b0;
        end
        burst_left = 0;
        while (owed_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Delays and a tick before any thread exists: the idle error, taking
    // precedence over a zero tick count, and the unused mode.
    task automatic test_idle_and_errors();
        send_command(prs_pkg::MODE_DELAY, 6'd0, 32'd0);
        send_command(MODE_UNUSED, 6'd63, 32'hFFFF_FFFF);
        send_command(prs_pkg::MODE_TICK, 6'd0, 32'd0);
        send_command(prs_pkg::MODE_DELAY, 6'd5, 32'hFFFF_FFFF);
        wait_until_drained();
    endtask

    // Registration of the idle thread, the top priority, priorities out of
    // range and priorities already in use.
    task automatic test_registration();
        send_command(prs_pkg::MODE_REGISTER, 6'd0, 32'd7);
        send_command(prs_pkg::MODE_REGISTER, 6'd0, 32'd0);
        send_command(prs_pkg::MODE_REGISTER, 6'd33, 32'd1);
        send_command(prs_pkg::MODE_REGISTER, 6'd63, 32'hFFFF_FFFF);
        send_command(prs_pkg::MODE_REGISTER, 6'd32, 32'd0);
        send_command(prs_pkg::MODE_REGISTER, 6'd32, 32'd0);
        send_command(prs_pkg::MODE_REGISTER, 6'd1, 32'd0);
        wait_until_drained();
    endtask

    // Delays of the running thread: a zero count, a count of one that wakes
    // on the next tick, a count that needs several ticks, and the largest
    // count, which parks priority 1 for the rest of the run. The scheduler
    // also falls back to idle and tries a delay from there.
    task automatic test_delay_and_wake();
        send_command(prs_pkg::MODE_DELAY, 6'd0, 32'd0);
        send_command(prs_pkg::MODE_DELAY, 6'd0, 32'd1);
        send_command(prs_pkg::MODE_TICK, 6'd0, 32'd0);
        send_command(prs_pkg::MODE_DELAY, 6'd0, 32'd2);
        send_command(prs_pkg::MODE_DELAY, 6'd0, 32'hFFFF_FFFF);
        send_command(prs_pkg::MODE_TICK, 6'd0, 32'd0);
        send_command(prs_pkg::MODE_DELAY, 6'd0, 32'd5);
        send_command(prs_pkg::MODE_TICK, 6'd0, 32'd0);
        send_command(prs_pkg::MODE_REGISTER, 6'd16, 32'd0);
        send_command(prs_pkg::MODE_REGISTER, 6'd17, 32'd0);
        send_command(prs_pkg::MODE_DELAY, 6'd0, 32'd3);
        send_command(prs_pkg::MODE_DELAY, 6'd0, 32'd1);
        send_command(prs_pkg::MODE_TICK, 6'd0, 32'd0);
        send_command(prs_pkg::MODE_TICK, 6'd0, 32'd0);
        wait_until_drained();
    endtask

    // Random mix of commands. Delays mostly use short counts so that threads
    // keep waking up; a few use zero or a full 32-bit count. Halfway through,
    // the sender holds off until every owed result has arrived.
    task automatic test_random_traffic(input int count);
        int                          roll;
        logic [prs_pkg::MODE_W-1:0]  op;
        logic [prs_pkg::PRIO_W-1:0]  prio;
        logic [prs_pkg::TICKS_W-1:0] ticks;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                wait_until_drained();

            roll = $urandom_range(0, 99);
            if (roll < 40)
                op = prs_pkg::MODE_TICK;
            else if (roll < 75)
                op = prs_pkg::MODE_DELAY;
            else if (roll < 93)
                op = prs_pkg::MODE_REGISTER;
            else
                op = MODE_UNUSED;

            if ($urandom_range(0, 9) == 0)
                prio = prs_pkg::PRIO_W'($urandom_range(PRIO_COUNT + 2, 63));
            else
                prio = prs_pkg::PRIO_W'($urandom_range(0, PRIO_COUNT + 1));

            roll = $urandom_range(0, 99);
            if (roll < 70)
                ticks = $urandom_range(1, 4);
            else if (roll < 92)
                ticks = $urandom_range(5, 40);
            else if (roll < 97)
                ticks = '0;
            else
                ticks = $urandom;

            send_command(op, prio, ticks);
        end
    endtask

    // The receiver switches between three behaviours in random turns: no
    // back-pressure at all, scattered random stalls, or occasional long
    // stalls.
    initial
    begin : res_ready_pattern
        int pattern;
        int pattern_left;
        int stall_left;
        res_bus.ready = 1'b0;
        pattern       = 0;
        pattern_left  = 0;
        stall_left    = 0;
        forever
        begin
            @(negedge clk);
            if (pattern_left == 0)
            begin
                pattern      = $urandom_range(0, 2);
                pattern_left = $urandom_range(50, 300);
            end
            pattern_left--;
            case (pattern)
                0:
                    res_bus.ready <= 1'b1;
                1:
                    res_bus.ready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    if (stall_left == 0 && $urandom_range(0, 4) == 0)
                        stall_left = $urandom_range(2, 12);
                    if (stall_left > 0)
                    begin
                        res_bus.ready <= 1'b0;
                        stall_left--;
                    end
                    else
                    begin
                        res_bus.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Compares every result transaction with the oldest owed result.
    always @(posedge clk)
    begin : result_check
        sched_result_t owed;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            error_seen[res_bus.error_code]++;
            if (res_bus.switch_request)
                switch_seen++;
            if (owed_results.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, got %0d/%0b/%0d",
                         $time, res_bus.next_thread, res_bus.switch_request,
                         res_bus.error_code);
                mismatch_count++;
            end
            else
            begin
                owed = owed_results.pop_front();
                if (res_bus.next_thread !== owed.next_thread)
                begin
                    $display("%0t ns: next_thread expected %0d, got %0d",
                             $time, owed.next_thread, res_bus.next_thread);
                    mismatch_count++;
                end
                if (res_bus.switch_request !== owed.switch_request)
                begin
                    $display("%0t ns: switch_request expected %0b, got %0b",
                             $time, owed.switch_request, res_bus.switch_request);
                    mismatch_count++;
                end
                if (res_bus.error_code !== owed.error_code)
                begin
                    $display("%0t ns: error_code expected %0d, got %0d",
                             $time, owed.error_code, res_bus.error_code);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends a run that has hung. The slowest correct run is well under a
    // millisecond, so this leaves a wide margin.
    initial
    begin : watchdog
        #5ms;
        $display("Timed out with %0d results still owed", owed_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : main_sequence
        // Every input is known from time zero, and the expected state starts
        // as the block does after reset.
        rst_n                   = 1'b0;
        cmd_bus.valid           = 1'b0;
        cmd_bus.mode            = prs_pkg::MODE_TICK;
        cmd_bus.thread_priority = '0;
        cmd_bus.delay_ticks     = '0;
        ready_set      = '0;
        delayed_set    = '0;
        claimed_set    = '0;
        running_thread = '0;
        running_known  = 1'b0;
        for (int i = 0; i < PRIO_COUNT; i++)
            wait_left[i] = '0;
        burst_left     = 0;
        cmd_held       = 1'b0;
        mismatch_count = 0;
        tick_count     = 0;
        delay_count    = 0;
        register_count = 0;
        unused_count   = 0;
        switch_seen    = 0;
        for (int i = 0; i < 4; i++)
            error_seen[i] = 0;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_idle_and_errors();
        test_registration();
        test_delay_and_wake();
        test_random_traffic(RANDOM_ITEMS);

        // Let the last results arrive, then allow a quiet spell in which a
        // stray result would still be caught.
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (owed_results.size() != 0)
        begin
            $display("%0t ns: %0d results expected but never received",
                     $time, owed_results.size());
            mismatch_count++;
        end

        $display("Covered %0d ticks, %0d delays, %0d registrations, %0d unused-mode commands",
                 tick_count, delay_count, register_count, unused_count);
        $display("Results: %0d switches; error codes ok/idle/zero/used seen %0d/%0d/%0d/%0d",
                 switch_seen, error_seen[prs_pkg::ERR_OK], error_seen[prs_pkg::ERR_IDLE],
                 error_seen[prs_pkg::ERR_ZERO], error_seen[prs_pkg::ERR_PRIO_USED]);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
